FILE: design/quadrotor_observer_state_feedback_assert.svh
// ----------------------------------------------------------------------------
// Quadrotor observer assertion macros
// Shared property forms for the quadrotor observer checkers.
// ----------------------------------------------------------------------------
`ifndef QUADROTOR_OBSERVER_STATE_FEEDBACK_ASSERT_SVH
`define QUADROTOR_OBSERVER_STATE_FEEDBACK_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define QOFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qofb: next-cycle property failed");

// The expression must never be true outside reset.
`define QOFB_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("qofb: forbidden condition seen");

`endif

FILE: design/qofb_pkg.sv
// ----------------------------------------------------------------------------
// Quadrotor observer package
// Word types, operand codes, fixed-point constants and the sequencer program.
// ----------------------------------------------------------------------------
package qofb_pkg;

  typedef struct packed {
    logic signed [31:0] set_x;
    logic signed [31:0] set_y;
    logic signed [31:0] set_z;
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
    logic signed [31:0] accel_z;
    logic signed [31:0] flow_dx;
    logic signed [31:0] flow_dy;
    logic signed [31:0] range_dist;
    logic               motors_off;
    logic               reset_estimate;
  } in_word_t;

  typedef struct packed {
    logic [15:0] motor_1;
    logic [15:0] motor_2;
    logic [15:0] motor_3;
    logic [15:0] motor_4;
  } out_word_t;

  typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL} alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [2:0] {OP_ADD, OP_SUB, OP_MUL, OP_OUT, OP_BRK, OP_END} op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] dst;
    logic [6:0] src_a;
    logic [6:0] src_b;
  } inst_t;

  localparam int RF_DEPTH = 32;
  localparam int RF_AW    = 5;
  localparam int NUM_EST  = 9;
  localparam int PC_W     = 7;

  // Register file operands.
  localparam logic [6:0] R_POS_X  = 7'd0;
  localparam logic [6:0] R_POS_Y  = 7'd1;
  localparam logic [6:0] R_POS_Z  = 7'd2;
  localparam logic [6:0] R_YAW    = 7'd3;
  localparam logic [6:0] R_PITCH  = 7'd4;
  localparam logic [6:0] R_ROLL   = 7'd5;
  localparam logic [6:0] R_VEL_X  = 7'd6;
  localparam logic [6:0] R_VEL_Y  = 7'd7;
  localparam logic [6:0] R_VEL_Z  = 7'd8;
  localparam logic [6:0] R_PREV_X = 7'd9;
  localparam logic [6:0] R_PREV_Y = 7'd10;
  localparam logic [6:0] R_WX     = 7'd11;
  localparam logic [6:0] R_WY     = 7'd12;
  localparam logic [6:0] R_WZ     = 7'd13;
  localparam logic [6:0] R_AZ     = 7'd14;
  localparam logic [6:0] R_EX     = 7'd15;
  localparam logic [6:0] R_EY     = 7'd16;
  localparam logic [6:0] R_ER     = 7'd17;
  localparam logic [6:0] R_T      = 7'd18;
  localparam logic [6:0] R_T2     = 7'd19;
  localparam logic [6:0] R_WXD    = 7'd20;
  localparam logic [6:0] R_WYD    = 7'd21;
  localparam logic [6:0] R_TX     = 7'd22;
  localparam logic [6:0] R_TY     = 7'd23;
  localparam logic [6:0] R_TZ     = 7'd24;
  localparam logic [6:0] R_FZ     = 7'd25;
  localparam logic [6:0] R_AX     = 7'd26;
  localparam logic [6:0] R_AY     = 7'd27;
  localparam logic [6:0] R_BZ     = 7'd28;
  localparam logic [6:0] R_CF     = 7'd29;
  localparam logic [6:0] R_M      = 7'd30;

  // Input field operands.
  localparam logic [6:0] I_SET_X   = 7'd32;
  localparam logic [6:0] I_SET_Y   = 7'd33;
  localparam logic [6:0] I_SET_Z   = 7'd34;
  localparam logic [6:0] I_GYRO_X  = 7'd35;
  localparam logic [6:0] I_GYRO_Y  = 7'd36;
  localparam logic [6:0] I_GYRO_Z  = 7'd37;
  localparam logic [6:0] I_ACCEL_Z = 7'd38;
  localparam logic [6:0] I_FLOW_DX = 7'd39;
  localparam logic [6:0] I_FLOW_DY = 7'd40;
  localparam logic [6:0] I_RANGE   = 7'd41;

  // Constant operands.
  localparam logic [6:0] K_ZERO = 7'd64;
  localparam logic [6:0] K_D2R  = 7'd65;
  localparam logic [6:0] K_GRAV = 7'd66;
  localparam logic [6:0] K_DT   = 7'd67;
  localparam logic [6:0] K_KV   = 7'd68;
  localparam logic [6:0] K_KW   = 7'd69;
  localparam logic [6:0] K_KPX  = 7'd70;
  localparam logic [6:0] K_MA   = 7'd71;
  localparam logic [6:0] K_MB   = 7'd72;
  localparam logic [6:0] K_MC   = 7'd73;
  localparam logic [6:0] K_LZ   = 7'd74;
  localparam logic [6:0] K_LP   = 7'd75;
  localparam logic [6:0] K_LR   = 7'd76;
  localparam logic [6:0] K_LVX  = 7'd77;
  localparam logic [6:0] K_LVY  = 7'd78;
  localparam logic [6:0] K_LVZ  = 7'd79;
  localparam logic [6:0] K_RATE = 7'd80;
  localparam logic [6:0] K_RX   = 7'd81;
  localparam logic [6:0] K_VY   = 7'd82;
  localparam logic [6:0] K_WX   = 7'd83;
  localparam logic [6:0] K_D    = 7'd84;
  localparam logic [6:0] K_RY   = 7'd85;
  localparam logic [6:0] K_VX   = 7'd86;
  localparam logic [6:0] K_WY   = 7'd87;
  localparam logic [6:0] K_YAW  = 7'd88;
  localparam logic [6:0] K_WZ   = 7'd89;
  localparam logic [6:0] K_Z    = 7'd90;
  localparam logic [6:0] K_VZ   = 7'd91;
  localparam logic [6:0] K_F    = 7'd92;

  // Motor output slots.
  localparam logic [6:0] M_1 = 7'd0;
  localparam logic [6:0] M_2 = 7'd1;
  localparam logic [6:0] M_3 = 7'd2;
  localparam logic [6:0] M_4 = 7'd3;

  // Q32.32 constants, rounded to nearest with ties up.
  function automatic logic signed [63:0] qofb_const(input logic [4:0] idx);
    logic signed [63:0] v;
    case (idx)
      5'd0:    v = 64'sd0;
      5'd1:    v = 64'sd74961321;
      5'd2:    v = 64'sd42133629174;
      5'd3:    v = 64'sd8589935;
      5'd4:    v = 64'sd35154785605;
      5'd5:    v = 64'sd17577392803;
      5'd6:    v = 64'sd16452130;
      5'd7:    v = {32'sd4311242, 32'd0};
      5'd8:    v = {32'sd28468908, 32'd0};
      5'd9:    v = {32'sd142271, 32'd0};
      5'd10:   v = 64'sd95870173916;
      5'd11:   v = 64'sd58924856;
      5'd12:   v = 64'sd55300008;
      5'd13:   v = 64'sd967515386;
      5'd14:   v = 64'sd939130750;
      5'd15:   v = {32'sd96, 32'd0};
      5'd16:   v = {32'sd500, 32'd0};
      5'd17:   v = 64'sd55507513;
      5'd18:   v = 64'sd15208307;
      5'd19:   v = 64'sd9897151;
      5'd20:   v = 64'sd257698;
      5'd21:   v = 64'sd55518809;
      5'd22:   v = 64'sd15209553;
      5'd23:   v = 64'sd9901317;
      5'd24:   v = 64'sd5608111;
      5'd25:   v = 64'sd4166634;
      5'd26:   v = 64'sd3299864348;
      5'd27:   v = 64'sd2496010494;
      5'd28:   v = 64'sd1398836489;
      default: v = 64'sd0;
    endcase
    return v;
  endfunction

  function automatic inst_t mk(input op_t op, input logic [6:0] d,
                               input logic [6:0] a, input logic [6:0] b);
    inst_t i;
    i.op    = op;
    i.dst   = d[4:0];
    i.src_a = a;
    i.src_b = b;
    return i;
  endfunction

  // One control tick as a straight-line program for the shared unit.
  function automatic inst_t qofb_prog(input logic [PC_W-1:0] pc);
    inst_t i;
    case (pc)
      7'd0:   i = mk(OP_MUL, R_WX, I_GYRO_X, K_D2R);
      7'd1:   i = mk(OP_MUL, R_WY, I_GYRO_Y, K_D2R);
      7'd2:   i = mk(OP_MUL, R_WZ, I_GYRO_Z, K_D2R);
      7'd3:   i = mk(OP_MUL, R_AZ, K_GRAV, I_ACCEL_Z);
      7'd4:   i = mk(OP_SUB, R_EX, K_ZERO, I_FLOW_DX);
      7'd5:   i = mk(OP_MUL, R_T, K_KV, R_VEL_X);
      7'd6:   i = mk(OP_ADD, R_EX, R_EX, R_T);
      7'd7:   i = mk(OP_MUL, R_T, K_KW, R_WY);
      7'd8:   i = mk(OP_SUB, R_EX, R_EX, R_T);
      7'd9:   i = mk(OP_SUB, R_EY, K_ZERO, I_FLOW_DY);
      7'd10:  i = mk(OP_MUL, R_T, K_KV, R_VEL_Y);
      7'd11:  i = mk(OP_ADD, R_EY, R_EY, R_T);
      7'd12:  i = mk(OP_MUL, R_T, K_KW, R_WX);
      7'd13:  i = mk(OP_ADD, R_EY, R_EY, R_T);
      7'd14:  i = mk(OP_SUB, R_ER, R_POS_Z, I_RANGE);
      7'd15:  i = mk(OP_MUL, R_T, K_DT, R_VEL_X);
      7'd16:  i = mk(OP_ADD, R_POS_X, R_POS_X, R_T);
      7'd17:  i = mk(OP_MUL, R_T, K_DT, R_VEL_Y);
      7'd18:  i = mk(OP_ADD, R_POS_Y, R_POS_Y, R_T);
      7'd19:  i = mk(OP_MUL, R_T, K_LZ, R_ER);
      7'd20:  i = mk(OP_SUB, R_T, K_ZERO, R_T);
      7'd21:  i = mk(OP_ADD, R_T, R_T, R_VEL_Z);
      7'd22:  i = mk(OP_MUL, R_T, K_DT, R_T);
      7'd23:  i = mk(OP_ADD, R_POS_Z, R_POS_Z, R_T);
      7'd24:  i = mk(OP_MUL, R_T, K_DT, R_WZ);
      7'd25:  i = mk(OP_ADD, R_YAW, R_YAW, R_T);
      7'd26:  i = mk(OP_MUL, R_T, K_LP, R_EX);
      7'd27:  i = mk(OP_SUB, R_T, K_ZERO, R_T);
      7'd28:  i = mk(OP_ADD, R_T, R_T, R_WY);
      7'd29:  i = mk(OP_MUL, R_T, K_DT, R_T);
      7'd30:  i = mk(OP_ADD, R_PITCH, R_PITCH, R_T);
      7'd31:  i = mk(OP_MUL, R_T, K_LR, R_EY);
      7'd32:  i = mk(OP_ADD, R_T, R_T, R_WX);
      7'd33:  i = mk(OP_MUL, R_T, K_DT, R_T);
      7'd34:  i = mk(OP_ADD, R_ROLL, R_ROLL, R_T);
      7'd35:  i = mk(OP_MUL, R_T, K_LVX, R_EX);
      7'd36:  i = mk(OP_SUB, R_T, K_ZERO, R_T);
      7'd37:  i = mk(OP_MUL, R_T2, K_GRAV, R_PITCH);
      7'd38:  i = mk(OP_ADD, R_T, R_T, R_T2);
      7'd39:  i = mk(OP_MUL, R_T, K_DT, R_T);
      7'd40:  i = mk(OP_ADD, R_VEL_X, R_VEL_X, R_T);
      7'd41:  i = mk(OP_MUL, R_T, K_LVY, R_EY);
      7'd42:  i = mk(OP_SUB, R_T, K_ZERO, R_T);
      7'd43:  i = mk(OP_MUL, R_T2, K_GRAV, R_ROLL);
      7'd44:  i = mk(OP_SUB, R_T, R_T, R_T2);
      7'd45:  i = mk(OP_MUL, R_T, K_DT, R_T);
      7'd46:  i = mk(OP_ADD, R_VEL_Y, R_VEL_Y, R_T);
      7'd47:  i = mk(OP_SUB, R_T, R_AZ, K_GRAV);
      7'd48:  i = mk(OP_MUL, R_T2, K_LVZ, R_ER);
      7'd49:  i = mk(OP_SUB, R_T, R_T, R_T2);
      7'd50:  i = mk(OP_MUL, R_T, K_DT, R_T);
      7'd51:  i = mk(OP_ADD, R_VEL_Z, R_VEL_Z, R_T);
      7'd52:  i = mk(OP_BRK, R_T, K_ZERO, K_ZERO);
      7'd53:  i = mk(OP_SUB, R_T, R_WX, R_PREV_X);
      7'd54:  i = mk(OP_MUL, R_WXD, R_T, K_RATE);
      7'd55:  i = mk(OP_SUB, R_T, R_WY, R_PREV_Y);
      7'd56:  i = mk(OP_MUL, R_WYD, R_T, K_RATE);
      7'd57:  i = mk(OP_SUB, R_T, R_POS_Y, I_SET_Y);
      7'd58:  i = mk(OP_MUL, R_TX, K_KPX, R_T);
      7'd59:  i = mk(OP_MUL, R_T, K_RX, R_ROLL);
      7'd60:  i = mk(OP_SUB, R_TX, R_TX, R_T);
      7'd61:  i = mk(OP_MUL, R_T, K_VY, R_VEL_Y);
      7'd62:  i = mk(OP_ADD, R_TX, R_TX, R_T);
      7'd63:  i = mk(OP_MUL, R_T, K_WX, R_WX);
      7'd64:  i = mk(OP_SUB, R_TX, R_TX, R_T);
      7'd65:  i = mk(OP_MUL, R_T, K_D, R_WXD);
      7'd66:  i = mk(OP_SUB, R_TX, R_TX, R_T);
      7'd67:  i = mk(OP_SUB, R_T, R_POS_X, I_SET_X);
      7'd68:  i = mk(OP_MUL, R_T, K_KPX, R_T);
      7'd69:  i = mk(OP_SUB, R_TY, K_ZERO, R_T);
      7'd70:  i = mk(OP_MUL, R_T, K_RY, R_PITCH);
      7'd71:  i = mk(OP_SUB, R_TY, R_TY, R_T);
      7'd72:  i = mk(OP_MUL, R_T, K_VX, R_VEL_X);
      7'd73:  i = mk(OP_SUB, R_TY, R_TY, R_T);
      7'd74:  i = mk(OP_MUL, R_T, K_WY, R_WY);
      7'd75:  i = mk(OP_SUB, R_TY, R_TY, R_T);
      7'd76:  i = mk(OP_MUL, R_T, K_D, R_WYD);
      7'd77:  i = mk(OP_SUB, R_TY, R_TY, R_T);
      7'd78:  i = mk(OP_MUL, R_T, K_YAW, R_YAW);
      7'd79:  i = mk(OP_SUB, R_TZ, K_ZERO, R_T);
      7'd80:  i = mk(OP_MUL, R_T, K_WZ, R_WZ);
      7'd81:  i = mk(OP_SUB, R_TZ, R_TZ, R_T);
      7'd82:  i = mk(OP_SUB, R_T, R_POS_Z, I_SET_Z);
      7'd83:  i = mk(OP_MUL, R_T, K_Z, R_T);
      7'd84:  i = mk(OP_SUB, R_FZ, K_ZERO, R_T);
      7'd85:  i = mk(OP_MUL, R_T, K_VZ, R_VEL_Z);
      7'd86:  i = mk(OP_SUB, R_FZ, R_FZ, R_T);
      7'd87:  i = mk(OP_ADD, R_FZ, R_FZ, K_F);
      7'd88:  i = mk(OP_MUL, R_AX, K_MA, R_TX);
      7'd89:  i = mk(OP_MUL, R_AY, K_MA, R_TY);
      7'd90:  i = mk(OP_MUL, R_BZ, K_MB, R_TZ);
      7'd91:  i = mk(OP_MUL, R_CF, K_MC, R_FZ);
      7'd92:  i = mk(OP_SUB, R_M, K_ZERO, R_AX);
      7'd93:  i = mk(OP_SUB, R_M, R_M, R_AY);
      7'd94:  i = mk(OP_SUB, R_M, R_M, R_BZ);
      7'd95:  i = mk(OP_ADD, R_M, R_M, R_CF);
      7'd96:  i = mk(OP_OUT, M_1, R_M, K_ZERO);
      7'd97:  i = mk(OP_SUB, R_M, K_ZERO, R_AX);
      7'd98:  i = mk(OP_ADD, R_M, R_M, R_AY);
      7'd99:  i = mk(OP_ADD, R_M, R_M, R_BZ);
      7'd100: i = mk(OP_ADD, R_M, R_M, R_CF);
      7'd101: i = mk(OP_OUT, M_2, R_M, K_ZERO);
      7'd102: i = mk(OP_ADD, R_M, R_AX, R_AY);
      7'd103: i = mk(OP_SUB, R_M, R_M, R_BZ);
      7'd104: i = mk(OP_ADD, R_M, R_M, R_CF);
      7'd105: i = mk(OP_OUT, M_3, R_M, K_ZERO);
      7'd106: i = mk(OP_SUB, R_M, R_AX, R_AY);
      7'd107: i = mk(OP_ADD, R_M, R_M, R_BZ);
      7'd108: i = mk(OP_ADD, R_M, R_M, R_CF);
      7'd109: i = mk(OP_OUT, M_4, R_M, K_ZERO);
      7'd110: i = mk(OP_ADD, R_PREV_X, R_WX, K_ZERO);
      7'd111: i = mk(OP_ADD, R_PREV_Y, R_WY, K_ZERO);
      default: i = mk(OP_END, R_T, K_ZERO, K_ZERO);
    endcase
    return i;
  endfunction

endpackage

FILE: design/quadrotor_observer_state_feedback.sv
// ----------------------------------------------------------------------------
// Quadrotor observer and state-feedback controller
// One control tick per input word: observer update, LQR law and motor mixing.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                          | Carries
//   --------+--------------------------------+-------------------------------
//   in      | in_valid, in_ready, in_data    | setpoint, sensors, mode flags
//   out     | out_valid, out_ready, out_data | four 16-bit motor commands
//
// A small sequencer steps through a fixed program of about 110 instructions,
// whose arithmetic runs on one shared saturating adder and one 32x32
// multiplier. A multiply takes longer than an add or subtract, and with motors
// disabled a word ends after the observer update.
// Reset is synchronous and active low; it zeroes all estimates and rates.
// in_ready is high only while idle. A finished word moves into the output
// register as soon as that register is free, so the next word can be taken
// while the previous result still waits for out_ready.
//
module quadrotor_observer_state_feedback (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qofb_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qofb_pkg::out_word_t  out_data
);
  import qofb_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_EXEC, S_WAIT, S_DONE} state_t;

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  in_word_t        in_r, in_nxt;
  logic [15:0]     motor_r [4];
  logic [15:0]     motor_nxt [4];
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_r, out_nxt;

  inst_t              inst;
  logic signed [63:0] rf_a;
  logic signed [63:0] rf_b;
  logic signed [63:0] opa;
  logic signed [63:0] opb;
  alu_req_t           alu_req;
  logic               alu_done;
  logic signed [63:0] alu_res;
  logic               rf_wr_en;
  logic               clr_est;

  // Widen a Q16.16 field to Q32.32.
  function automatic logic signed [63:0] fq(input logic [31:0] x);
    return {{16{x[31]}}, x, 16'd0};
  endfunction

  // Operand fetch: register file, input field or constant table.
  function automatic logic signed [63:0] pick(input logic [6:0] src,
                                              input logic signed [63:0] rfv,
                                              input in_word_t w);
    logic signed [63:0] v;
    if (src[6]) begin
      v = qofb_const(src[4:0]);
    end else if (src[5]) begin
      case (src)
        I_SET_X:   v = fq(w.set_x);
        I_SET_Y:   v = fq(w.set_y);
        I_SET_Z:   v = fq(w.set_z);
        I_GYRO_X:  v = fq(w.gyro_x);
        I_GYRO_Y:  v = fq(w.gyro_y);
        I_GYRO_Z:  v = fq(w.gyro_z);
        I_ACCEL_Z: v = fq(w.accel_z);
        I_FLOW_DX: v = fq(w.flow_dx);
        I_FLOW_DY: v = fq(w.flow_dy);
        I_RANGE:   v = fq(w.range_dist);
        default:   v = 64'sd0;
      endcase
    end else begin
      v = rfv;
    end
    return v;
  endfunction

  // Integer part of the mixed value, limited to the motor range.
  function automatic logic [15:0] mcmd(input logic signed [63:0] v);
    logic [15:0] m;
    if (v[63] || (v == 64'sd0)) begin
      m = 16'd0;
    end else if (|v[62:48]) begin
      m = 16'hFFFF;
    end else begin
      m = v[47:32];
    end
    return m;
  endfunction

  assign inst = qofb_prog(pc_r);
  assign opa  = pick(inst.src_a, rf_a, in_r);
  assign opb  = pick(inst.src_b, rf_b, in_r);

  assign in_ready = (state_r == S_IDLE);
  assign clr_est  = in_valid && in_ready && in_data.reset_estimate;
  assign rf_wr_en = (state_r == S_WAIT) && alu_done;

  always_comb begin
    alu_req.start = (state_r == S_EXEC) &&
                    ((inst.op == OP_ADD) || (inst.op == OP_SUB) || (inst.op == OP_MUL));
    case (inst.op)
      OP_SUB:  alu_req.op = ALU_SUB;
      OP_MUL:  alu_req.op = ALU_MUL;
      default: alu_req.op = ALU_ADD;
    endcase
  end

  qofb_regfile u_rf (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_est   (clr_est),
    .rd_addr_a (inst.src_a[RF_AW-1:0]),
    .rd_addr_b (inst.src_b[RF_AW-1:0]),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b),
    .wr_en     (rf_wr_en),
    .wr_addr   (inst.dst),
    .wr_data   (alu_res)
  );

  qofb_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (opa),
    .opb   (opb),
    .done  (alu_done),
    .res   (alu_res)
  );

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    in_nxt        = in_r;
    motor_nxt     = motor_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    // A taken result frees the output register.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          pc_nxt    = '0;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        case (inst.op)
          OP_END: begin
            state_nxt = S_DONE;
          end
          OP_BRK: begin
            // With motors disabled the tick ends after the observer update.
            if (in_r.motors_off) begin
              for (int k = 0; k < 4; k++) begin
                motor_nxt[k] = 16'd0;
              end
              state_nxt = S_DONE;
            end else begin
              pc_nxt = pc_r + 7'd1;
            end
          end
          default: state_nxt = S_EXEC;
        endcase
      end
      S_EXEC: begin
        if (inst.op == OP_OUT) begin
          motor_nxt[inst.dst[1:0]] = mcmd(opa);
          pc_nxt    = pc_r + 7'd1;
          state_nxt = S_FETCH;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (alu_done) begin
          pc_nxt    = pc_r + 7'd1;
          state_nxt = S_FETCH;
        end
      end
      S_DONE: begin
        // Hand the word over once the output register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          out_nxt.motor_1 = motor_r[0];
          out_nxt.motor_2 = motor_r[1];
          out_nxt.motor_3 = motor_r[2];
          out_nxt.motor_4 = motor_r[3];
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_r    <= in_nxt;
    motor_r <= motor_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: design/qofb_alu.sv
// ----------------------------------------------------------------------------
// Quadrotor observer shared arithmetic unit
// Saturating Q32.32 add, subtract and a four-step 32x32 partial product multiply.
// ----------------------------------------------------------------------------
module qofb_alu (
  input  logic                      clk,
  input  logic                      rst_n,
  input  qofb_pkg::alu_req_t        req,
  input  logic signed [63:0]        opa,
  input  logic signed [63:0]        opb,
  output logic                      done,
  output logic signed [63:0]        res
);
  import qofb_pkg::*;

  localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] SMIN = {1'b1, {63{1'b0}}};

  logic               busy_r;
  logic [2:0]         step_r;
  logic [63:0]        ma_r;
  logic [63:0]        mb_r;
  logic               neg_r;
  logic [127:0]       acc_r;
  logic signed [63:0] res_r;
  logic               done_r;

  logic [64:0]  sum_w;
  logic [64:0]  dif_w;
  logic [63:0]  mag_a;
  logic [63:0]  mag_b;
  logic [31:0]  half_a;
  logic [31:0]  half_b;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [96:0]  cq;
  logic [63:0]  mul_res;

  function automatic logic [63:0] sat65(input logic [64:0] s);
    if (s[64] != s[63]) begin
      return s[64] ? SMIN : SMAX;
    end
    return s[63:0];
  endfunction

  assign sum_w = {opa[63], opa} + {opb[63], opb};
  assign dif_w = {opa[63], opa} - {opb[63], opb};
  assign mag_a = opa[63] ? (~opa + 64'd1) : opa;
  assign mag_b = opb[63] ? (~opb + 64'd1) : opb;

  assign half_a = step_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign half_b = step_r[0] ? mb_r[63:32] : mb_r[31:0];
  assign pp     = 64'(half_a) * 64'(half_b);

  always_comb begin
    case (step_r[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // Floor the product: the magnitude of a negative result with dropped fraction bits grows by one.
  always_comb begin
    cq = {1'b0, acc_r[127:32]} + 97'(neg_r && (|acc_r[31:0]));
    if (!neg_r) begin
      mul_res = (|cq[96:63]) ? SMAX : cq[63:0];
    end else if ((|cq[96:64]) || (cq[63] && (|cq[62:0]))) begin
      mul_res = SMIN;
    end else begin
      mul_res = ~cq[63:0] + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 3'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        case (req.op)
          ALU_ADD: begin
            res_r  <= sat65(sum_w);
            done_r <= 1'b1;
          end
          ALU_SUB: begin
            res_r  <= sat65(dif_w);
            done_r <= 1'b1;
          end
          default: begin
            ma_r   <= mag_a;
            mb_r   <= mag_b;
            neg_r  <= opa[63] ^ opb[63];
            acc_r  <= '0;
            step_r <= 3'd0;
            busy_r <= 1'b1;
          end
        endcase
      end else if (busy_r) begin
        if (step_r == 3'd4) begin
          res_r  <= mul_res;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          acc_r  <= acc_r + pp_sh;
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: design/qofb_regfile.sv
// ----------------------------------------------------------------------------
// Quadrotor observer register file
// Estimates and scratch values, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module qofb_regfile (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clr_est,
  input  logic [4:0]               rd_addr_a,
  input  logic [4:0]               rd_addr_b,
  output logic signed [63:0]       rd_data_a,
  output logic signed [63:0]       rd_data_b,
  input  logic                     wr_en,
  input  logic [4:0]               wr_addr,
  input  logic signed [63:0]       wr_data
);
  import qofb_pkg::*;

  logic signed [63:0]  mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] vld_r;
  logic signed [63:0]  rd_a_r;
  logic signed [63:0]  rd_b_r;
  logic                va_r;
  logic                vb_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  // An entry that was never written, or was cleared, reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      va_r <= vld_r[rd_addr_a];
      vb_r <= vld_r[rd_addr_b];
      if (clr_est) begin
        vld_r[NUM_EST-1:0] <= '0;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data_a = va_r ? rd_a_r : 64'sd0;
  assign rd_data_b = vb_r ? rd_b_r : 64'sd0;

endmodule

FILE: design/qofb_checker.sv
// ----------------------------------------------------------------------------
// Quadrotor observer port checker
// Watches the handshake ports of the controller over time.
// ----------------------------------------------------------------------------
`include "quadrotor_observer_state_feedback_assert.svh"

module qofb_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input qofb_pkg::out_word_t  out_data
);

  // A waiting result word must stay put until it is taken.
  `QOFB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // Accepting a word starts the program, so the input side closes next cycle.
  `QOFB_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready)

  // An offered result word never carries unknown bits.
  `QOFB_ASSERT_NEVER(a_out_known, clk, rst_n, out_valid && $isunknown(out_data))

endmodule

bind quadrotor_observer_state_feedback qofb_checker u_qofb_checker (.*);

FILE: tb/sv/quadrotor_observer_state_feedback_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrotor observer state feedback testbench
// Drives control ticks through the valid/ready input channel. An in-bench
// Q32.32 model of the observer, the LQR law and the motor mixer predicts each
// motor word. The model is checked field by field against the result channel
// under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module quadrotor_observer_state_feedback_tb;
  import qofb_pkg::*;

  localparam int NUM_RANDOM = 1900;
  localparam longint QMAX = 64'sh7fffffffffffffff;
  localparam longint QMIN = 64'sh8000000000000000;
  localparam longint ONE  = 64'sh100000000;

  // A tick waiting to be driven. When hold_off is set, the sender waits until
  // every outstanding motor word has come back before it offers this tick.
  typedef struct {
    in_word_t word;
    bit       hold_off;
  } tick_item_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  tick_item_t tick_queue[$];
  out_word_t  motor_expect[$];
  int         ticks_total;
  int         ticks_sent;
  int         errors;
  bit         in_fire_q;

  // Observer and controller state held by the predictor.
  longint est_pos_x, est_pos_y, est_pos_z, est_yaw, est_pitch, est_roll;
  longint est_vel_x, est_vel_y, est_vel_z, last_rate_x, last_rate_y;

  quadrotor_observer_state_feedback dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Fixed-point helpers. All values are signed Q32.32 and saturate at the
  // 64-bit limits after every operation.
  // ------------------------------------------------------------------------

  // round(num / den * 2^32), with ties rounded up.
  function automatic longint q_const(input longint unsigned num,
                                     input longint unsigned den);
    logic [127:0] scaled;
    scaled = ({64'd0, num} << 33) / {64'd0, den};
    return longint'((scaled + 128'd1) >> 1);
  endfunction

  function automatic longint q_clamp(input logic signed [129:0] v);
    if (v > 130'(QMAX)) return QMAX;
    if (v < 130'(QMIN)) return QMIN;
    return longint'(v);
  endfunction

  function automatic longint q_add(input longint a, input longint b);
    return q_clamp(130'(a) + 130'(b));
  endfunction

  function automatic longint q_sub(input longint a, input longint b);
    return q_clamp(130'(a) - 130'(b));
  endfunction

  // Exact product, floored to Q32.32 by the arithmetic shift.
  function automatic longint q_mul(input longint a, input longint b);
    logic signed [129:0] prod;
    prod = 130'(a) * 130'(b);
    return q_clamp(prod >>> 32);
  endfunction

  function automatic longint q_field(input logic signed [31:0] f);
    return longint'(f) <<< 16;
  endfunction

  function automatic logic [15:0] motor_from_q(input longint v);
    longint whole;
    if (v <= 0) return 16'd0;
    whole = v >>> 32;
    return (whole > 65535) ? 16'hffff : whole[15:0];
  endfunction

  // One control tick: observer update, feedback law and mixing. Updates the
  // predictor state and returns the motor word the block should produce.
  function automatic out_word_t predict_motors(input in_word_t w);
    longint grav, dt, kv, kw, kpx, kd, ma, mb, mc, d2r;
    longint dx, dy, dz, wx, wy, wz, az, nx, ny, rg;
    longint ex, ey, er, t, wxd, wyd, tx, ty, tz, fz, ax, ay, bz, cf;
    out_word_t m;
    grav = q_const(981, 100);
    dt   = q_const(2, 1000);
    kv   = q_const(818511136, 100000000);
    kw   = q_const(409255568, 100000000);
    kpx  = q_const(383056, 100000000);
    kd   = q_const(6, 100000);
    d2r  = q_const(64'd31415926535897932, 64'd1800000000000000000);
    ma   = 4311242 * ONE;
    mb   = 28468908 * ONE;
    mc   = 142271 * ONE;
    dx = q_field(w.set_x);
    dy = q_field(w.set_y);
    dz = q_field(w.set_z);
    wx = q_mul(q_field(w.gyro_x), d2r);
    wy = q_mul(q_field(w.gyro_y), d2r);
    wz = q_mul(q_field(w.gyro_z), d2r);
    az = q_mul(grav, q_field(w.accel_z));
    nx = q_field(w.flow_dx);
    ny = q_field(w.flow_dy);
    rg = q_field(w.range_dist);

    // Estimate reset leaves the stored rates alone.
    if (w.reset_estimate) begin
      est_pos_x = 0; est_pos_y = 0; est_pos_z = 0;
      est_yaw = 0; est_pitch = 0; est_roll = 0;
      est_vel_x = 0; est_vel_y = 0; est_vel_z = 0;
    end

    ex = q_sub(q_add(q_sub(0, nx), q_mul(kv, est_vel_x)), q_mul(kw, wy));
    ey = q_add(q_add(q_sub(0, ny), q_mul(kv, est_vel_y)), q_mul(kw, wx));
    er = q_sub(est_pos_z, rg);

    // The updates run in order, so the velocity terms see the new angles.
    est_pos_x = q_add(est_pos_x, q_mul(dt, est_vel_x));
    est_pos_y = q_add(est_pos_y, q_mul(dt, est_vel_y));
    t = q_add(q_sub(0, q_mul(q_const(223215143, 10000000), er)), est_vel_z);
    est_pos_z = q_add(est_pos_z, q_mul(dt, t));
    est_yaw = q_add(est_yaw, q_mul(dt, wz));
    t = q_add(q_sub(0, q_mul(q_const(137195122, 64'd10000000000), ex)), wy);
    est_pitch = q_add(est_pitch, q_mul(dt, t));
    t = q_add(q_mul(q_const(128755365, 64'd10000000000), ey), wx);
    est_roll = q_add(est_roll, q_mul(dt, t));
    t = q_add(q_sub(0, q_mul(q_const(22526723, 100000000), ex)), q_mul(grav, est_pitch));
    est_vel_x = q_add(est_vel_x, q_mul(dt, t));
    t = q_sub(q_sub(0, q_mul(q_const(218658417, 1000000000), ey)), q_mul(grav, est_roll));
    est_vel_y = q_add(est_vel_y, q_mul(dt, t));
    t = q_sub(q_sub(az, grav), q_mul(96 * ONE, er));
    est_vel_z = q_add(est_vel_z, q_mul(dt, t));

    // With the motors off the observer still runs but the rates are kept.
    if (w.motors_off) return '0;

    wxd = q_mul(q_sub(wx, last_rate_x), 500 * ONE);
    wyd = q_mul(q_sub(wy, last_rate_y), 500 * ONE);

    tx = q_mul(kpx, q_sub(est_pos_y, dy));
    tx = q_sub(tx, q_mul(q_const(1292385, 100000000), est_roll));
    tx = q_add(tx, q_mul(q_const(354096, 100000000), est_vel_y));
    tx = q_sub(tx, q_mul(q_const(230436, 100000000), wx));
    tx = q_sub(tx, q_mul(kd, wxd));

    ty = q_sub(0, q_mul(kpx, q_sub(est_pos_x, dx)));
    ty = q_sub(ty, q_mul(q_const(1292648, 100000000), est_pitch));
    ty = q_sub(ty, q_mul(q_const(354125, 100000000), est_vel_x));
    ty = q_sub(ty, q_mul(q_const(230533, 100000000), wy));
    ty = q_sub(ty, q_mul(kd, wyd));

    tz = q_sub(q_sub(0, q_mul(q_const(130574, 100000000), est_yaw)),
               q_mul(q_const(97012, 100000000), wz));

    fz = q_sub(0, q_mul(q_const(76830954, 100000000), q_sub(est_pos_z, dz)));
    fz = q_sub(fz, q_mul(q_const(58114773, 100000000), est_vel_z));
    fz = q_add(fz, q_const(325692, 1000000));

    ax = q_mul(ma, tx);
    ay = q_mul(ma, ty);
    bz = q_mul(mb, tz);
    cf = q_mul(mc, fz);
    m.motor_1 = motor_from_q(q_add(q_sub(q_sub(q_sub(0, ax), ay), bz), cf));
    m.motor_2 = motor_from_q(q_add(q_add(q_add(q_sub(0, ax), ay), bz), cf));
    m.motor_3 = motor_from_q(q_add(q_sub(q_add(ax, ay), bz), cf));
    m.motor_4 = motor_from_q(q_add(q_add(q_sub(ax, ay), bz), cf));

    last_rate_x = wx;
    last_rate_y = wy;
    return m;
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus construction.
  // ------------------------------------------------------------------------

  // Signed Q16.16 value uniformly in +-span units.
  function automatic logic [31:0] q16_near(input int span);
    return 32'($urandom_range(0, 2 * span * 65536)) - 32'(span * 65536);
  endfunction

  function automatic in_word_t flight_word();
    in_word_t w;
    w.set_x          = q16_near(3);
    w.set_y          = q16_near(3);
    w.set_z          = q16_near(2) + 32'sh10000;
    w.gyro_x         = q16_near(250);
    w.gyro_y         = q16_near(250);
    w.gyro_z         = q16_near(250);
    w.accel_z        = q16_near(1) + 32'sh10000;
    w.flow_dx        = q16_near(20);
    w.flow_dy        = q16_near(20);
    w.range_dist     = q16_near(1) + 32'sh10000;
    w.motors_off     = ($urandom_range(0, 9) == 0);
    w.reset_estimate = ($urandom_range(0, 24) == 0);
    return w;
  endfunction

  // Fully random fields, covering every bit and the saturation paths.
  function automatic in_word_t noise_word();
    in_word_t w;
    w.set_x = $urandom(); w.set_y = $urandom(); w.set_z = $urandom();
    w.gyro_x = $urandom(); w.gyro_y = $urandom(); w.gyro_z = $urandom();
    w.accel_z = $urandom(); w.flow_dx = $urandom(); w.flow_dy = $urandom();
    w.range_dist = $urandom();
    w.motors_off = $urandom_range(0, 1);
    w.reset_estimate = $urandom_range(0, 1);
    return w;
  endfunction

  task automatic add_tick(input in_word_t w, input bit hold);
    tick_item_t it;
    it.word = w;
    it.hold_off = hold;
    tick_queue.push_back(it);
  endtask

  // ------------------------------------------------------------------------
  // Driver. Inputs change on the falling edge; the acceptance flag comes from
  // the rising edge before it. The idling pattern follows the progress of the
  // run: none, then sender idle 60%, then receiver stall 60%, then both 11%.
  // ------------------------------------------------------------------------
  always @(negedge clk) begin
    int idle_pct, stall_pct;
    bit offer;
    in_word_t next_word;
    idle_pct = 0;
    stall_pct = 0;
    if (ticks_sent > 1500) begin
      idle_pct = 11; stall_pct = 11;
    end else if (ticks_sent > 1000) begin
      stall_pct = 60;
    end else if (ticks_sent > 500) begin
      idle_pct = 60;
    end

    if (rst_n) begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
      if (!in_valid || in_fire_q) begin
        offer = 1'b0;
        next_word = in_data;
        if (tick_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          if (!tick_queue[0].hold_off || motor_expect.size() == 0) begin
            next_word = tick_queue[0].word;
            void'(tick_queue.pop_front());
            offer = 1'b1;
          end
        end
        in_valid <= offer;
        in_data  <= next_word;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Monitor. Accepted ticks are predicted in order; each accepted motor word
  // is compared with the oldest prediction.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t want;
    in_fire_q <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      motor_expect.push_back(predict_motors(in_data));
      ticks_sent <= ticks_sent + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (motor_expect.size() == 0) begin
        errors <= errors + 1;
        $display("%0t: unexpected motor word %h", $realtime, out_data);
      end else begin
        want = motor_expect.pop_front();
        if (out_data.motor_1 !== want.motor_1 || out_data.motor_2 !== want.motor_2 ||
            out_data.motor_3 !== want.motor_3 || out_data.motor_4 !== want.motor_4) begin
          errors <= errors + 1;
          $display("%0t: motor word expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                   $realtime, want.motor_1, want.motor_2, want.motor_3, want.motor_4,
                   out_data.motor_1, out_data.motor_2, out_data.motor_3,
                   out_data.motor_4);
        end
      end
    end
  end

  initial begin
    in_word_t w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    in_fire_q = 1'b0;
    ticks_sent = 0;
    errors = 0;
    est_pos_x = 0; est_pos_y = 0; est_pos_z = 0;
    est_yaw = 0; est_pitch = 0; est_roll = 0;
    est_vel_x = 0; est_vel_y = 0; est_vel_z = 0;
    last_rate_x = 0; last_rate_y = 0;

    // Directed ticks: all zero, hover, motors off, estimate reset, and the
    // field extremes that drive every sum into saturation.
    add_tick('0, 1'b0);
    w = '0;
    w.accel_z = 32'sh10000; w.range_dist = 32'sh10000; w.set_z = 32'sh10000;
    add_tick(w, 1'b0);
    add_tick(w, 1'b0);
    w.motors_off = 1'b1;
    add_tick(w, 1'b0);
    w.motors_off = 1'b0;
    w.gyro_x = 32'sh5a0000;
    add_tick(w, 1'b0);
    w.reset_estimate = 1'b1;
    add_tick(w, 1'b0);
    w = '1;
    add_tick(w, 1'b0);
    w = '0;
    w.set_x = 32'h7fffffff; w.set_y = 32'h7fffffff; w.set_z = 32'h7fffffff;
    w.gyro_x = 32'h7fffffff; w.gyro_y = 32'h7fffffff; w.gyro_z = 32'h7fffffff;
    w.accel_z = 32'h7fffffff; w.flow_dx = 32'h7fffffff; w.flow_dy = 32'h7fffffff;
    w.range_dist = 32'h7fffffff;
    add_tick(w, 1'b0);
    add_tick(w, 1'b0);
    w.set_x = 32'h80000000; w.set_y = 32'h80000000; w.set_z = 32'h80000000;
    w.gyro_x = 32'h80000000; w.gyro_y = 32'h80000000; w.gyro_z = 32'h80000000;
    w.accel_z = 32'h80000000; w.flow_dx = 32'h80000000; w.flow_dy = 32'h80000000;
    w.range_dist = 32'h80000000;
    add_tick(w, 1'b0);
    add_tick(w, 1'b0);
    w.motors_off = 1'b1;
    add_tick(w, 1'b0);
    w = '0;
    w.reset_estimate = 1'b1;
    add_tick(w, 1'b0);
    w.reset_estimate = 1'b0;
    w.set_z = 32'sh10000; w.accel_z = 32'sh20000;
    add_tick(w, 1'b0);
    add_tick(w, 1'b0);

    // Random part: mostly flight-like ticks with occasional full-range noise.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      w = ($urandom_range(0, 9) == 0) ? noise_word() : flight_word();
      add_tick(w, (i == 200 || i == 1200));
    end
    ticks_total = tick_queue.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (ticks_sent == ticks_total && motor_expect.size() == 0);
    repeat (1200) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog sized from the worst-case tick time plus idling, taken several times over.
  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/qofb_pkg.sv
design/qofb_alu.sv
design/qofb_regfile.sv
design/quadrotor_observer_state_feedback.sv
design/qofb_checker.sv
tb/sv/quadrotor_observer_state_feedback_tb.sv
